[hdl/rational_arith_reduce_assert.svh]
// Assertion macros for the rational arithmetic block.
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RAR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational_arith_reduce check failed");
// Next-cycle implication.
`define RAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational_arith_reduce check failed");
`else
`define RAR_ASSERT_NOW(label, clk, rst, ante, cons)
`define RAR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/rar_pkg.sv]
package rar_pkg;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] MS_P1  = 2'd0;
  localparam logic [1:0] MS_P2  = 2'd1;
  localparam logic [1:0] MS_DEN = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_ADD, S_GCD,
    S_DVN0, S_DVN, S_DVD0, S_DVD, S_OUT
  } state_t;

  typedef struct packed {
    logic       idle;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       add_en;
    logic       gcd_en;
    logic       div_ld;
    logic       div_sel;   // 0 numerator, 1 denominator
    logic       div_step;
    logic       qn_ld;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic in_acc;
    logic err;
    logic num_zero;
    logic gcd_done;
    logic out_free;
  } sts_t;

endpackage

[hdl/rar_if.sv]
interface rar_in_if #(parameter int WIDTH = 16);
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [WIDTH-1:0] a_num;
  logic signed [WIDTH-1:0] a_den;
  logic signed [WIDTH-1:0] b_num;
  logic signed [WIDTH-1:0] b_den;
  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] res_num;
  logic [30:0]        res_den;
  logic [1:0]         status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface

[hdl/rar_ctrl.sv]
module rar_ctrl
  import rar_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int PW = 2 * WIDTH;
  localparam int CW = $clog2(PW);

  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic last;

  assign last = (cnt == CW'(PW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DVN || state == S_DVD) cnt <= cnt + 1'b1;
      else cnt <= '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (sts.in_acc) state_next = S_MUL0;
      S_MUL0: state_next = sts.err ? S_OUT : S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_ADD;
      S_ADD:  state_next = S_GCD;
      S_GCD: begin
        priority if (sts.num_zero) state_next = S_OUT;
        else if (sts.gcd_done) state_next = S_DVN0;
        else state_next = S_GCD;
      end
      S_DVN0: state_next = S_DVN;
      S_DVN:  if (last) state_next = S_DVD0;
      S_DVD0: state_next = S_DVD;
      S_DVD:  if (last) state_next = S_OUT;
      S_OUT:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.idle = 1'b1;
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_P1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_P2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DEN;
      end
      S_ADD:  cmd.add_en = 1'b1;
      S_GCD:  cmd.gcd_en = 1'b1;
      S_DVN0: cmd.div_ld = 1'b1;
      S_DVN:  cmd.div_step = 1'b1;
      S_DVD0: begin
        cmd.qn_ld   = 1'b1;
        cmd.div_ld  = 1'b1;
        cmd.div_sel = 1'b1;
      end
      S_DVD:  cmd.div_step = 1'b1;
      S_OUT:  cmd.out_ld = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[hdl/rar_dpath.sv]
module rar_dpath
  import rar_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  rar_in_if.sink   in_ch,
  rar_out_if.source out_ch,
  input  cmd_t     cmd,
  output sts_t     sts
);

  localparam int PW = 2 * WIDTH;

  logic [1:0]       op;
  logic [WIDTH-1:0] ma, mad, mb, mbd;
  logic             sa, sb;
  status_t          code;
  logic [PW-1:0]    p1, p2, den;
  logic [PW-1:0]    x, y, nr, dr;
  logic             neg;
  logic [PW-1:0]    q, r, qn;
  logic             out_valid;

  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic             an_s, ad_s, bn_s, bd_s;
  logic [WIDTH-1:0] mx, my;
  logic [PW-1:0]    prod, sum;
  logic             sum_neg;
  logic [PW:0]      rs;
  logic             rs_ge;
  logic [PW+32:0]   nx, dx;

  assign an_s = in_ch.a_num[WIDTH-1];
  assign ad_s = in_ch.a_den[WIDTH-1];
  assign bn_s = in_ch.b_num[WIDTH-1];
  assign bd_s = in_ch.b_den[WIDTH-1];
  assign an_m = an_s ? (~in_ch.a_num) + 1'b1 : in_ch.a_num;
  assign ad_m = ad_s ? (~in_ch.a_den) + 1'b1 : in_ch.a_den;
  assign bn_m = bn_s ? (~in_ch.b_num) + 1'b1 : in_ch.b_num;
  assign bd_m = bd_s ? (~in_ch.b_den) + 1'b1 : in_ch.b_den;

  assign in_ch.ready = cmd.idle;

  // Take the item apart into magnitudes, fold denominator signs in.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op  <= in_ch.op;
      ma  <= an_m;
      mad <= ad_m;
      mb  <= bn_m;
      mbd <= bd_m;
      sa  <= an_s ^ ad_s;
      sb  <= bn_s ^ bd_s ^ (in_ch.op == OP_SUB);
      priority if (ad_m == '0 || bd_m == '0) code <= ST_ZDEN;
      else if (in_ch.op == OP_DIV && bn_m == '0) code <= ST_DIV0;
      else code <= ST_OK;
    end
  end

  // One shared multiplier, three products in turn.
  always_comb begin
    unique case (cmd.mul_sel)
      MS_P1: begin
        mx = ma;
        my = (op == OP_MUL) ? mb : mbd;
      end
      MS_P2: begin
        mx = mb;
        my = mad;
      end
      default: begin
        mx = mad;
        my = (op == OP_DIV) ? mb : mbd;
      end
    endcase
  end
  assign prod = PW'(mx) * PW'(my);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MS_P1:   p1 <= prod;
        MS_P2:   p2 <= prod;
        default: den <= prod;
      endcase
    end
  end

  // Signed-magnitude sum of the two cross products.
  always_comb begin
    priority if (sa == sb) begin
      sum     = p1 + p2;
      sum_neg = sa;
    end else if (p1 >= p2) begin
      sum     = p1 - p2;
      sum_neg = sa;
    end else begin
      sum     = p2 - p1;
      sum_neg = sb;
    end
  end

  // Binary GCD: common factors of two shift nr and dr along with x and y.
  always_ff @(posedge clk) begin
    if (cmd.add_en) begin
      if (op == OP_ADD || op == OP_SUB) begin
        x   <= sum;
        nr  <= sum;
        neg <= sum_neg;
      end else begin
        x   <= p1;
        nr  <= p1;
        neg <= sa ^ sb;
      end
      y  <= den;
      dr <= den;
    end else if (cmd.gcd_en && x != '0) begin
      priority if (!x[0] && !y[0]) begin
        x  <= x >> 1;
        y  <= y >> 1;
        nr <= nr >> 1;
        dr <= dr >> 1;
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x >= y) begin
        x <= x - y;
      end else begin
        y <= y - x;
      end
    end
  end

  // Restoring divider, one quotient bit a cycle; divisor is the odd GCD part.
  assign rs    = {r, q[PW-1]};
  assign rs_ge = (rs >= {1'b0, y});

  always_ff @(posedge clk) begin
    if (cmd.div_ld) begin
      q <= cmd.div_sel ? dr : nr;
      r <= '0;
    end else if (cmd.div_step) begin
      r <= rs_ge ? PW'(rs - {1'b0, y}) : rs[PW-1:0];
      q <= {q[PW-2:0], rs_ge};
    end
    if (cmd.qn_ld) qn <= q;
  end

  assign nx = {{33{1'b0}}, qn};
  assign dx = {{33{1'b0}}, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_ch.status <= code;
      if (code != ST_OK || nr == '0) begin
        out_ch.res_num <= '0;
        out_ch.res_den <= 31'd1;
      end else begin
        out_ch.res_num <= neg ? (~nx[32:0]) + 33'd1 : nx[32:0];
        out_ch.res_den <= dx[30:0];
      end
    end
  end

  assign out_ch.valid = out_valid;

  assign sts.in_acc   = in_ch.valid && in_ch.ready;
  assign sts.err      = (code != ST_OK);
  assign sts.num_zero = (nr == '0);
  assign sts.gcd_done = (x == '0);
  assign sts.out_free = !out_valid || out_ch.ready;

endmodule

[hdl/rational_arith_reduce.sv]
// rational_arith_reduce: add, subtract, multiply or divide two signed
// fractions and reduce the result to lowest terms.
// Input channel in_ch carries op and the two fractions; an item is taken
// when valid and ready are both high. Output channel out_ch carries the
// reduced numerator (sign), positive denominator and a status code.
// Ready is high only while no item is in work: one item at a time.
// An error item goes from the first product step straight to output, and
// a zero numerator leaves the GCD step straight for output. A normal
// item forms its three products in turn and their sum, then runs the
// binary GCD loop (one shift or subtract per cycle), then two restoring
// divisions, numerator then denominator, then loads the output register.
// The GCD loop and the shared bit-serial divider take most of the time.
// Reset (synchronous, active high) returns the controller to idle and
// drops any result not yet taken.
// When the receiver stalls the result holds in the output register; the
// next item is still taken and worked, and waits to load until the
// output register frees.
`include "rational_arith_reduce_assert.svh"
module rational_arith_reduce
  import rar_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  rar_in_if.sink    in_ch,
  rar_out_if.source out_ch
);

  // Commands from controller, status back from datapath.
  cmd_t cmd;
  sts_t sts;

  rar_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rar_dpath #(.WIDTH(WIDTH)) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  // Once an item is taken, hold ready low while it is worked.
  `RAR_ASSERT_NEXT(a_one_in_flight, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready)
  // A shown result never has a zero denominator.
  `RAR_ASSERT_NOW(a_den_nonzero, clk, rst, out_ch.valid, out_ch.res_den != 31'd0)
  // An error result is always 0/1.
  `RAR_ASSERT_NOW(a_err_zero, clk, rst, out_ch.valid && out_ch.status != ST_OK,
                  out_ch.res_num == 33'sd0 && out_ch.res_den == 31'd1)
  // Never load a new result over one still waiting.
  `RAR_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.out_ld, !out_ch.valid || out_ch.ready)

endmodule
